// File: rtl/core/kmc_pkg.sv
// ----------------------------------------------------------------------------
// kmc_pkg
// Shared types, character codes and match tables for the key line method
// checker.
// ----------------------------------------------------------------------------
package kmc_pkg;

    // Character codes
    localparam logic [7:0] C_LF    = 8'h0A;
    localparam logic [7:0] C_CR    = 8'h0D;
    localparam logic [7:0] C_TAB   = 8'h09;
    localparam logic [7:0] C_SPACE = 8'h20;
    localparam logic [7:0] C_QUOTE = 8'h22;
    localparam logic [7:0] C_COMMA = 8'h2C;
    localparam logic [7:0] C_EQUAL = 8'h3D;

    // Line phase codes: 0..10 prefix bytes matched, then key line or other line
    localparam logic [3:0] LINE_BEGIN = 4'd0;
    localparam logic [3:0] LINE_KEY   = 4'd11;
    localparam logic [3:0] LINE_OTHER = 4'd12;

    // Word lengths
    localparam logic [2:0] METHOD_LEN = 3'd6;
    localparam logic [2:0] NONE_LEN   = 3'd4;

    // Attribute parse phase
    typedef enum logic [2:0] {
        FP_NAME_LEAD   = 3'd0,
        FP_NAME        = 3'd1,
        FP_NAME_TRAIL  = 3'd2,
        FP_VALUE_LEAD  = 3'd3,
        FP_VALUE       = 3'd4,
        FP_VALUE_TRAIL = 3'd5,
        FP_SKIP        = 3'd6
    } t_field_phase;

    // One input beat
    typedef struct packed {
        logic [7:0] text_byte;
        logic       byte_present;
        logic       end_of_text;
    } t_item;

    // "#EXT-X-KEY:"
    function automatic logic [7:0] prefix_char(input logic [3:0] idx);
        logic [7:0] c;
        case (idx)
            4'd0:    c = 8'h23;
            4'd1:    c = 8'h45;
            4'd2:    c = 8'h58;
            4'd3:    c = 8'h54;
            4'd4:    c = 8'h2D;
            4'd5:    c = 8'h58;
            4'd6:    c = 8'h2D;
            4'd7:    c = 8'h4B;
            4'd8:    c = 8'h45;
            4'd9:    c = 8'h59;
            4'd10:   c = 8'h3A;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // "METHOD"
    function automatic logic [7:0] method_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = 8'h4D;
            3'd1:    c = 8'h45;
            3'd2:    c = 8'h54;
            3'd3:    c = 8'h48;
            3'd4:    c = 8'h4F;
            3'd5:    c = 8'h44;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // "NONE"
    function automatic logic [7:0] none_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = 8'h4E;
            3'd1:    c = 8'h4F;
            3'd2:    c = 8'h4E;
            3'd3:    c = 8'h45;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic is_ws(input logic [7:0] c);
        return (c == C_SPACE) || (c == C_TAB) || (c == C_CR) || (c == C_LF);
    endfunction

endpackage

// File: rtl/core/kmc_in_reg.sv
// ----------------------------------------------------------------------------
// kmc_in_reg
// Input register: captures one beat and holds it until the scanner takes it.
// ----------------------------------------------------------------------------
module kmc_in_reg (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  kmc_pkg::t_item i_item,
    output logic           o_stall,
    input  logic           i_take,
    output logic           o_valid,
    output kmc_pkg::t_item o_item
);

    logic           r_valid;
    kmc_pkg::t_item r_item;
    logic           w_load;

    // Load when empty or when the held beat leaves this cycle
    assign w_load  = !r_valid || i_take;
    assign o_stall = !w_load;

    // Hold valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= i_valid;
        end
    end

    // Capture payload
    always_ff @(posedge i_clk) begin
        if (w_load && i_valid) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// File: rtl/core/kmc_scan.sv
// ----------------------------------------------------------------------------
// kmc_scan
// Line and attribute scanner: updates the parse state for one beat per cycle
// while beats are taken, and produces the verdict at end of text.
// ----------------------------------------------------------------------------
module kmc_scan (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_take,
    input  kmc_pkg::t_item i_item,
    output logic           o_verdict
);

    logic [3:0]            r_line_phase, n_line_phase;
    logic                  r_in_quotes, n_in_quotes;
    kmc_pkg::t_field_phase r_field_phase, n_field_phase;
    logic [2:0]            r_name_progress, n_name_progress;
    logic [2:0]            r_value_progress, n_value_progress;
    logic                  r_method_found, n_method_found;
    logic                  r_rejected, n_rejected;
    logic [7:0]            w_c;
    logic                  w_is_lf;

    assign w_c     = i_item.text_byte;
    assign w_is_lf = (w_c == kmc_pkg::C_LF);

    // Compute next parse state for the current beat
    always_comb begin
        n_line_phase     = r_line_phase;
        n_in_quotes      = r_in_quotes;
        n_field_phase    = r_field_phase;
        n_name_progress  = r_name_progress;
        n_value_progress = r_value_progress;
        n_method_found   = r_method_found;
        n_rejected       = r_rejected;
        o_verdict        = 1'b0;

        // Process a text byte other than line feed
        if (i_item.byte_present && !w_is_lf) begin
            if (r_line_phase < kmc_pkg::LINE_KEY) begin
                if (w_c == kmc_pkg::prefix_char(r_line_phase)) begin
                    n_line_phase = 4'(r_line_phase + 4'd1);
                    if (n_line_phase == kmc_pkg::LINE_KEY) begin
                        n_in_quotes      = 1'b0;
                        n_method_found   = 1'b0;
                        n_field_phase    = kmc_pkg::FP_NAME_LEAD;
                        n_name_progress  = 3'd0;
                        n_value_progress = 3'd0;
                    end
                end else begin
                    n_line_phase = kmc_pkg::LINE_OTHER;
                end
            end else if (r_line_phase == kmc_pkg::LINE_KEY) begin
                if (w_c == kmc_pkg::C_QUOTE) begin
                    n_in_quotes = !r_in_quotes;
                end
                if (w_c == kmc_pkg::C_COMMA && !r_in_quotes) begin
                    // End of attribute
                    if (r_field_phase == kmc_pkg::FP_VALUE_LEAD ||
                        r_field_phase == kmc_pkg::FP_VALUE) begin
                        n_rejected = 1'b1;
                    end
                    n_field_phase    = kmc_pkg::FP_NAME_LEAD;
                    n_name_progress  = 3'd0;
                    n_value_progress = 3'd0;
                end else begin
                    case (r_field_phase)
                        kmc_pkg::FP_NAME_LEAD, kmc_pkg::FP_NAME: begin
                            if (r_field_phase == kmc_pkg::FP_NAME_LEAD &&
                                kmc_pkg::is_ws(w_c)) begin
                                n_field_phase = r_field_phase;
                            end else if (r_name_progress < kmc_pkg::METHOD_LEN &&
                                w_c == kmc_pkg::method_char(r_name_progress)) begin
                                n_name_progress = 3'(r_name_progress + 3'd1);
                                n_field_phase = (n_name_progress == kmc_pkg::METHOD_LEN)
                                    ? kmc_pkg::FP_NAME_TRAIL : kmc_pkg::FP_NAME;
                            end else begin
                                n_field_phase = kmc_pkg::FP_SKIP;
                            end
                        end
                        kmc_pkg::FP_NAME_TRAIL: begin
                            if (kmc_pkg::is_ws(w_c)) begin
                                n_field_phase = r_field_phase;
                            end else if (w_c == kmc_pkg::C_EQUAL) begin
                                n_method_found = 1'b1;
                                n_field_phase  = kmc_pkg::FP_VALUE_LEAD;
                            end else begin
                                n_field_phase = kmc_pkg::FP_SKIP;
                            end
                        end
                        kmc_pkg::FP_VALUE_LEAD, kmc_pkg::FP_VALUE: begin
                            if (r_field_phase == kmc_pkg::FP_VALUE_LEAD &&
                                kmc_pkg::is_ws(w_c)) begin
                                n_field_phase = r_field_phase;
                            end else if (r_value_progress < kmc_pkg::NONE_LEN &&
                                w_c == kmc_pkg::none_char(r_value_progress)) begin
                                n_value_progress = 3'(r_value_progress + 3'd1);
                                n_field_phase = (n_value_progress == kmc_pkg::NONE_LEN)
                                    ? kmc_pkg::FP_VALUE_TRAIL : kmc_pkg::FP_VALUE;
                            end else begin
                                n_rejected    = 1'b1;
                                n_field_phase = kmc_pkg::FP_SKIP;
                            end
                        end
                        kmc_pkg::FP_VALUE_TRAIL: begin
                            if (!kmc_pkg::is_ws(w_c)) begin
                                n_rejected    = 1'b1;
                                n_field_phase = kmc_pkg::FP_SKIP;
                            end
                        end
                        default: begin
                            n_field_phase = r_field_phase;
                        end
                    endcase
                end
            end
        end

        // Close the line on line feed or end of text
        if ((i_item.byte_present && w_is_lf) || i_item.end_of_text) begin
            if (n_line_phase == kmc_pkg::LINE_KEY) begin
                if (n_field_phase == kmc_pkg::FP_VALUE_LEAD ||
                    n_field_phase == kmc_pkg::FP_VALUE) begin
                    n_rejected = 1'b1;
                end
                if (!n_method_found) begin
                    n_rejected = 1'b1;
                end
            end
            n_line_phase     = kmc_pkg::LINE_BEGIN;
            n_in_quotes      = 1'b0;
            n_method_found   = 1'b0;
            n_field_phase    = kmc_pkg::FP_NAME_LEAD;
            n_name_progress  = 3'd0;
            n_value_progress = 3'd0;
        end

        // Give the verdict and drop the sticky reject
        if (i_item.end_of_text) begin
            o_verdict  = n_rejected;
            n_rejected = 1'b0;
        end
    end

    // Advance parse state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_phase     <= kmc_pkg::LINE_BEGIN;
            r_in_quotes      <= 1'b0;
            r_field_phase    <= kmc_pkg::FP_NAME_LEAD;
            r_name_progress  <= 3'd0;
            r_value_progress <= 3'd0;
            r_method_found   <= 1'b0;
            r_rejected       <= 1'b0;
        end else if (i_take) begin
            r_line_phase     <= n_line_phase;
            r_in_quotes      <= n_in_quotes;
            r_field_phase    <= n_field_phase;
            r_name_progress  <= n_name_progress;
            r_value_progress <= n_value_progress;
            r_method_found   <= n_method_found;
            r_rejected       <= n_rejected;
        end
    end

endmodule

// File: rtl/core/kmc_out_reg.sv
// ----------------------------------------------------------------------------
// kmc_out_reg
// Result register: holds one verdict beat until the receiver takes it.
// ----------------------------------------------------------------------------
module kmc_out_reg (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_load,
    input  logic i_verdict,
    output logic o_free,
    output logic o_valid,
    output logic o_verdict,
    input  logic i_stall
);

    logic r_valid;
    logic r_verdict;

    // Slot is free when empty or when the held beat leaves this cycle
    assign o_free = !r_valid || !i_stall;

    // Hold valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    // Capture verdict
    always_ff @(posedge i_clk) begin
        if (o_free && i_load) begin
            r_verdict <= i_verdict;
        end
    end

    assign o_valid   = r_valid;
    assign o_verdict = r_verdict;

endmodule

// File: rtl/core/playlist_key_method_checker_top.sv
// Path: the end-of-text beat passes from the input register through the
// scanner into the result register, which then shows the verdict.
// Throughput: 1 beat per cycle; the only hold-off is an end beat meeting a
// stalled, still-full result register.
// Reset: synchronous active-low i_rst_n clears the parse state and both
// beat registers; the block accepts beats straight after reset.
// ----------------------------------------------------------------------------
// playlist_key_method_checker_top
// Checks that every key line of a playlist text uses METHOD=NONE.
// ----------------------------------------------------------------------------
module playlist_key_method_checker_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_text_byte,
    input  logic       i_byte_present,
    input  logic       i_end_of_text,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic       o_verdict
);

    kmc_pkg::t_item w_in_item;
    kmc_pkg::t_item w_held_item;
    logic           w_held_valid;
    logic           w_take;
    logic           w_out_free;
    logic           w_verdict;

    assign w_in_item.text_byte    = i_text_byte;
    assign w_in_item.byte_present = i_byte_present;
    assign w_in_item.end_of_text  = i_end_of_text;

    // Advance held beat unless it carries a verdict with no room for it
    assign w_take = w_held_valid && (!w_held_item.end_of_text || w_out_free);

    kmc_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .i_item  (w_in_item),
        .o_stall (o_in_stall),
        .i_take  (w_take),
        .o_valid (w_held_valid),
        .o_item  (w_held_item)
    );

    kmc_scan u_scan (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_take    (w_take),
        .i_item    (w_held_item),
        .o_verdict (w_verdict)
    );

    kmc_out_reg u_out_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (w_take && w_held_item.end_of_text),
        .i_verdict (w_verdict),
        .o_free    (w_out_free),
        .o_valid   (o_out_valid),
        .o_verdict (o_verdict),
        .i_stall   (i_out_stall)
    );

endmodule
